@@ hdl/usfp_pkg.sv @@
// Shared types and command codes for the UART/SPI flash programmer.
package usfp_pkg;

  localparam int PAGE_BYTES = 256;

  // UART commands and their replies
  localparam logic [7:0] CMD_PING     = 8'h55;
  localparam logic [7:0] ACK_PING     = 8'h56;
  localparam logic [7:0] CMD_LOAD     = 8'h10;
  localparam logic [7:0] ACK_LOAD     = 8'h11;
  localparam logic [7:0] CMD_ERASE    = 8'h30;
  localparam logic [7:0] ACK_ERASE    = 8'h31;
  localparam logic [7:0] DONE_ERASE   = 8'h32;
  localparam logic [7:0] CMD_PROGRAM  = 8'h40;
  localparam logic [7:0] ACK_PROGRAM  = 8'h41;
  localparam logic [7:0] DONE_PROGRAM = 8'h42;
  localparam logic [7:0] CMD_RESTART  = 8'hF0;
  localparam logic [7:0] ACK_RESTART  = 8'hF1;

  // SPI NOR opcodes
  localparam logic [7:0] SPI_WREN  = 8'h06;
  localparam logic [7:0] SPI_SE    = 8'h20;
  localparam logic [7:0] SPI_PP    = 8'h02;
  localparam logic [7:0] SPI_RDSR  = 8'h05;
  localparam logic [7:0] SPI_DUMMY = 8'h00;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       channel;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       restart;
  } out_word_t;

endpackage

@@ hdl/usfp_ram.sv @@
// Generic simple dual-port RAM with registered read.
module usfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/uart_spi_flash_programmer.sv @@
// UART-driven SPI NOR flash programmer: command sequencer around a page store.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-----------------------------
//  in_     | input     | in_valid / in_stall   | action, data_byte
//  out_    | output    | out_valid / out_stall | channel, out_byte, frame_end,
//          |           |                       | restart
//
// The reply to a word goes through a holding stage, then the output register:
// the page store read issued at accept returns in the next cycle and is
// folded into the reply. The reply waits in the holding stage while the output
// register is stalled; input stalls only while that stage is occupied.
// Reset is synchronous, active low; the page store is not cleared.
module uart_spi_flash_programmer #(
  parameter int PAGE_BYTES = usfp_pkg::PAGE_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  usfp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output usfp_pkg::out_word_t out_data
);

  import usfp_pkg::*;

  localparam int AW = $clog2(PAGE_BYTES);
  localparam int LW = $clog2(PAGE_BYTES + 1);
  localparam int IW = $clog2(PAGE_BYTES + 5);
  localparam logic [IW-1:0] HDR = IW'(4);

  typedef enum logic [3:0] {
    PH_CMD, PH_LEN, PH_DATA, PH_ADDR, PH_WREN, PH_XFER, PH_RDSR, PH_STAT
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic        pne_r, pne_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_ram_r, s1_ram_nxt;
  logic        s1_fresh_r, s1_fresh_nxt;
  out_word_t   s1_word_r, s1_word_nxt, s1_eff;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic          acc, s1_go;
  logic          res_valid, res_ram;
  out_word_t     res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;
  logic [IW-1:0] idx_inc, idx_inc2, idx_hdr, inc_hdr, frame_n;
  logic [7:0]    b;
  logic          spi_phase;

  assign acc      = in_valid && !in_stall;
  assign in_stall = s1_valid_r;
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign b        = in_data.data_byte;

  assign idx_inc  = idx_r + 1'b1;
  assign idx_inc2 = idx_r + IW'(2);
  assign idx_hdr  = idx_r - HDR;
  assign inc_hdr  = idx_inc - HDR;
  assign frame_n  = pne_r ? HDR + IW'(len_r) : HDR;

  assign spi_phase = (phase_r == PH_WREN) || (phase_r == PH_XFER) ||
                     (phase_r == PH_RDSR) || (phase_r == PH_STAT);

  usfp_ram #(
    .WIDTH (8),
    .DEPTH (PAGE_BYTES)
  ) u_page (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (b),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: state update and reply selection for the accepted word
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    addr_nxt  = addr_r;
    pne_nxt   = pne_r;
    res_valid = 1'b0;
    res_ram   = 1'b0;
    res       = '0;
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_raddr = inc_hdr[AW-1:0];

    if (acc && (in_data.action == spi_phase)) begin
      unique case (phase_r)
        PH_CMD: begin
          unique case (b)
            CMD_PING: begin
              res_valid = 1'b1;
              res.out_byte = ACK_PING;
            end
            CMD_LOAD: begin
              phase_nxt = PH_LEN;
              res_valid = 1'b1;
              res.out_byte = ACK_LOAD;
            end
            CMD_ERASE, CMD_PROGRAM: begin
              pne_nxt   = (b == CMD_PROGRAM);
              idx_nxt   = '0;
              phase_nxt = PH_ADDR;
              res_valid = 1'b1;
              res.out_byte = (b == CMD_PROGRAM) ? ACK_PROGRAM : ACK_ERASE;
            end
            CMD_RESTART: begin
              res_valid = 1'b1;
              res.out_byte = ACK_RESTART;
              res.restart = 1'b1;
            end
            default: ;
          endcase
        end
        PH_LEN: begin
          len_nxt   = LW'(b) + 1'b1;
          idx_nxt   = '0;
          sum_nxt   = '0;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          ram_we    = 1'b1;
          ram_waddr = idx_r[AW-1:0];
          sum_nxt   = sum_r + b;
          idx_nxt   = idx_inc;
          if (idx_inc >= IW'(len_r)) begin
            phase_nxt = PH_CMD;
            res_valid = 1'b1;
            res.out_byte = sum_r + b;
          end
        end
        PH_ADDR: begin
          addr_nxt = {addr_r[15:0], b};
          idx_nxt  = idx_inc;
          if (idx_inc >= IW'(3)) begin
            res_valid = 1'b1;
            if (len_r != '0) begin
              phase_nxt = PH_WREN;
              res.channel   = 1'b1;
              res.out_byte  = SPI_WREN;
              res.frame_end = 1'b1;
            end else begin
              phase_nxt = PH_CMD;
              res.out_byte = pne_r ? DONE_PROGRAM : DONE_ERASE;
            end
          end
        end
        PH_WREN: begin
          idx_nxt   = '0;
          phase_nxt = PH_XFER;
          res_valid = 1'b1;
          res.channel  = 1'b1;
          res.out_byte = pne_r ? SPI_PP : SPI_SE;
        end
        PH_XFER: begin
          // reply to a page byte goes back to the store
          if (idx_r >= HDR) begin
            ram_we    = 1'b1;
            ram_waddr = idx_hdr[AW-1:0];
          end
          idx_nxt   = idx_inc;
          res_valid = 1'b1;
          res.channel = 1'b1;
          if (idx_inc < frame_n) begin
            res.frame_end = (idx_inc2 == frame_n);
            priority if (idx_inc == IW'(1)) begin
              res.out_byte = addr_r[23:16];
            end else if (idx_inc == IW'(2)) begin
              res.out_byte = addr_r[15:8];
            end else if (idx_inc == IW'(3)) begin
              res.out_byte = addr_r[7:0];
            end else begin
              res_ram = 1'b1;
            end
          end else begin
            phase_nxt = PH_RDSR;
            res.out_byte = SPI_RDSR;
          end
        end
        PH_RDSR: begin
          phase_nxt = PH_STAT;
          res_valid = 1'b1;
          res.channel   = 1'b1;
          res.out_byte  = SPI_DUMMY;
          res.frame_end = 1'b1;
        end
        PH_STAT: begin
          res_valid = 1'b1;
          if (b[0]) begin
            phase_nxt = PH_RDSR;
            res.channel  = 1'b1;
            res.out_byte = SPI_RDSR;
          end else begin
            phase_nxt = PH_CMD;
            res.out_byte = pne_r ? DONE_PROGRAM : DONE_ERASE;
          end
        end
        default: phase_nxt = PH_CMD;
      endcase
    end
  end

  // reply pipeline: holding stage, then output register
  always_comb begin
    s1_eff = s1_word_r;
    if (s1_ram_r && s1_fresh_r) begin
      s1_eff.out_byte = ram_rdata;
    end

    s1_fresh_nxt = acc && res_valid;
    if (acc && res_valid) begin
      s1_valid_nxt = 1'b1;
      s1_word_nxt  = res;
      s1_ram_nxt   = res_ram;
    end else begin
      s1_valid_nxt = s1_valid_r && !s1_go;
      // latch the store data once it arrives
      s1_word_nxt  = s1_eff;
      s1_ram_nxt   = s1_ram_r && !s1_fresh_r;
    end

    if (s1_go) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = s1_eff;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
      out_word_nxt  = out_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CMD;
      len_r       <= '0;
      idx_r       <= '0;
      sum_r       <= '0;
      addr_r      <= '0;
      pne_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      s1_fresh_r  <= 1'b0;
      s1_ram_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      addr_r      <= addr_nxt;
      pne_r       <= pne_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_fresh_r  <= s1_fresh_nxt;
      s1_ram_r    <= s1_ram_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_word_r  <= s1_word_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule
